// ===== rtl/mwsa_pkg.sv =====
package mwsa_pkg;

	// result and register widths
	localparam int RES_W      = 38;
	localparam int WL_W       = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE  = 1'd1;

	// register reset values
	localparam logic [WL_W-1:0] WINDOW_LENGTH_RST = 7'd1;
	localparam logic            AVERAGE_MODE_RST  = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan;
		logic div_start;
		logic load_out;
	} mwsa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic need_div;
		logic div_busy;
	} mwsa_status_t;

endpackage

// ===== rtl/mwsa_div.sv =====
module mwsa_div #(
	parameter int DIVIDEND_W = 39,
	parameter int DIVISOR_W  = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [STEP_W-1:0]     steps_q;
	logic                  busy_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steps_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			steps_q <= STEP_W'(DIVIDEND_W);
		end else if (busy_q) begin
			steps_q <= steps_q - STEP_W'(1);
			if (steps_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/mwsa_datapath.sv =====
module mwsa_datapath #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mwsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mwsa_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic signed [SAMPLE_BITS-1:0]    sample_value,
	input  logic                             sample_is_null,
	input  logic                             partition_start,
	input  mwsa_pkg::mwsa_cmd_t              cmd,
	output mwsa_pkg::mwsa_status_t           status,
	output logic signed [mwsa_pkg::RES_W-1:0] window_result,
	output logic                             result_is_null
);

	localparam int PTR_W = $clog2(WINDOW_MAX);
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;
	localparam int CMP_W = CNT_W + mwsa_pkg::WL_W;
	localparam int EXT_W = SUM_W + mwsa_pkg::RES_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_MAX - 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(WINDOW_MAX);

	logic [mwsa_pkg::WL_W-1:0] window_length_q;
	logic                      average_mode_q;

	logic [SAMPLE_BITS-1:0] hist_mem [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]  hist_valid_q;
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       rows_q;
	logic [CNT_W-1:0]       left_q;
	logic [CNT_W-1:0]       count_q;
	logic signed [SUM_W-1:0] sum_q;

	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic                   rd_pend_s1;
	logic                   rd_take_s1;

	logic [CNT_W-1:0] rows_base;
	logic [CNT_W-1:0] rows_new;
	logic [CNT_W-1:0] span;
	logic [CMP_W-1:0] wl_ext;
	logic [CMP_W-1:0] max_ext;
	logic [CMP_W-1:0] rows_ext;
	logic [CMP_W-1:0] span_a;
	logic [CMP_W-1:0] span_b;
	logic             rd_issue;
	logic             is_null;
	logic             need_div;
	logic             div_busy;

	logic signed [SUM_W-1:0] sample_ext;
	logic signed [SUM_W-1:0] mem_ext;
	logic [SUM_W-1:0]        sum_mag;
	logic [SUM_W-1:0]        quotient;
	logic [SUM_W-1:0]        quo_signed;
	logic [SUM_W-1:0]        result_full;
	logic [EXT_W-1:0]        result_ext;

	function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_LAST : p - PTR_W'(1);
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= mwsa_pkg::WINDOW_LENGTH_RST;
			average_mode_q  <= mwsa_pkg::AVERAGE_MODE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mwsa_pkg::REG_WINDOW_LENGTH: window_length_q <= cfg_data[mwsa_pkg::WL_W-1:0];
				mwsa_pkg::REG_AVERAGE_MODE:  average_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// window span for the incoming row
	assign rows_base = partition_start ? '0 : rows_q;
	assign rows_new  = (rows_base == CNT_MAX) ? rows_base : rows_base + CNT_W'(1);
	assign wl_ext    = CMP_W'(window_length_q);
	assign max_ext   = CMP_W'(WINDOW_MAX);
	assign rows_ext  = CMP_W'(rows_new);
	assign span_a    = (wl_ext < max_ext) ? wl_ext : max_ext;
	assign span_b    = (span_a < rows_ext) ? span_a : rows_ext;
	assign span      = span_b[CNT_W-1:0];

	assign sample_ext = {{CNT_W{sample_value[SAMPLE_BITS-1]}}, sample_value};
	assign mem_ext    = {{CNT_W{rd_data_s1[SAMPLE_BITS-1]}}, rd_data_s1};
	assign rd_issue   = cmd.scan && (left_q != '0);

	// history store, one write and one read per cycle
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hist_mem[wr_ptr_q] <= sample_value;
		end
		if (rd_issue) begin
			rd_data_s1 <= hist_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_valid_q <= '0;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			rows_q       <= '0;
			left_q       <= '0;
			count_q      <= '0;
			sum_q        <= '0;
			rd_pend_s1   <= 1'b0;
			rd_take_s1   <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_issue;
			rd_take_s1 <= rd_issue && hist_valid_q[rd_ptr_q];
			if (cmd.accept) begin
				for (int i = 0; i < WINDOW_MAX; i++) begin
					hist_valid_q[i] <= (PTR_W'(i) == wr_ptr_q) ? !sample_is_null
						: (hist_valid_q[i] && !partition_start);
				end
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
				rd_ptr_q <= ptr_prev(wr_ptr_q);
				rows_q   <= rows_new;
				left_q   <= (span == '0) ? '0 : span - CNT_W'(1);
				// the current row is counted straight from the request
				if ((span != '0) && !sample_is_null) begin
					sum_q   <= sample_ext;
					count_q <= CNT_W'(1);
				end else begin
					sum_q   <= '0;
					count_q <= '0;
				end
			end else begin
				if (rd_issue) begin
					left_q   <= left_q - CNT_W'(1);
					rd_ptr_q <= ptr_prev(rd_ptr_q);
				end
				if (rd_take_s1) begin
					sum_q   <= sum_q + mem_ext;
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	assign is_null  = (count_q == '0);
	assign need_div = average_mode_q && !is_null;
	assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	mwsa_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_mag),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// truncation toward zero: divide the magnitude, then restore the sign
	assign quo_signed  = sum_q[SUM_W-1] ? SUM_W'(-quotient) : quotient;
	assign result_full = average_mode_q ? quo_signed : SUM_W'(sum_q);
	assign result_ext  = {{mwsa_pkg::RES_W{result_full[SUM_W-1]}}, result_full};

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_is_null <= is_null;
			window_result  <= is_null ? '0 : result_ext[mwsa_pkg::RES_W-1:0];
		end
	end

	assign status = '{
		scan_done: (left_q == '0) && !rd_pend_s1,
		need_div:  need_div,
		div_busy:  div_busy
	};

endmodule

// ===== rtl/mwsa_ctrl.sv =====
module mwsa_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  mwsa_pkg::mwsa_status_t status,
	output mwsa_pkg::mwsa_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} mwsa_state_t;

	mwsa_state_t state_q;
	mwsa_state_t state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) begin
					if (status.need_div) begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DIV: begin
				if (!status.div_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/moving_window_sum_average.sv =====
// channel   direction  handshake              payload
// in        request    in_valid / in_ready    sample_value, sample_is_null, partition_start
// out       result     out_valid / out_ready  window_result, result_is_null
// cfg       write      cfg_wr_en (no wait)    cfg_index, cfg_data
//
// one request at a time: accept, scan of the older rows of the span,
// divide for a non-null average only, and load;
// span = min(window_length, WINDOW_MAX, rows in partition)
// reset clears the control state, the validity marks and the registers to 1 / 1
// a waiting result holds back only the load of the next one, not its request
module moving_window_sum_average #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_wr_en,
	input  logic [mwsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mwsa_pkg::CFG_DATA_W-1:0]   cfg_data,
	// request channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [SAMPLE_BITS-1:0]     sample_value,
	input  logic                              sample_is_null,
	input  logic                              partition_start,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mwsa_pkg::RES_W-1:0] window_result,
	output logic                              result_is_null
);

	mwsa_pkg::mwsa_cmd_t    cmd;
	mwsa_pkg::mwsa_status_t status;

	// sequencer: accept, scan, divide, load
	mwsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// history ring, accumulator, divider and output register
	mwsa_datapath #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample_value    (sample_value),
		.sample_is_null  (sample_is_null),
		.partition_start (partition_start),
		.cmd             (cmd),
		.status          (status),
		.window_result   (window_result),
		.result_is_null  (result_is_null)
	);

endmodule

// ===== rtl/mwsa_checker.sv =====
module mwsa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [mwsa_pkg::RES_W-1:0] window_result,
	input logic                              result_is_null
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(window_result)
			&& $stable(result_is_null))
		else $error("result changed while stalled");

	// null result reads as zero
	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_is_null |-> window_result == '0)
		else $error("null result with nonzero value");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a new result only appears after the block was busy
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared from idle");

endmodule

bind moving_window_sum_average mwsa_checker u_checker (.*);
